// ===== hdl/euler_xyz_vector_rotation_macros.svh =====
// Assertion macros for the Euler XYZ rotation block.
// Included by files that carry concurrent assertions.
`ifndef EULER_XYZ_VECTOR_ROTATION_MACROS_SVH
`define EULER_XYZ_VECTOR_ROTATION_MACROS_SVH
`ifndef SYNTHESIS
`define EXR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define EXR_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define EXR_ASSERT(label, clk, rst_n, prop)
`define EXR_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== hdl/exr_pkg.sv =====
// Package for the Euler XYZ rotation block: formats, CORDIC table, helpers.
// No dependencies.
`default_nettype none
package exr_pkg;
  localparam int AngleBits    = 16;
  localparam int CordicStages = 16;
  localparam int NStages      = (CordicStages < 24) ? CordicStages : 24;
  localparam int AW           = 34;  // CORDIC datapath width
  localparam int QW           = 32;  // clamped Q30 values: [-2^30, 2^30]
  localparam logic signed [AW-1:0] Gain = 34'sd652032874;
  localparam logic signed [AW-1:0] OneQ = 34'sd1073741824;

  typedef logic signed [AW-1:0] cw_t;
  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    cw_t        x;
    cw_t        y;
    cw_t        z;
    logic       flip;
  } cstate_t;

  function automatic cw_t atan_tab(input int i);
    cw_t r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic q_t clamp_one(input logic signed [63:0] v);
    q_t r;
    if (v > 64'sd1073741824) r = 32'sd1073741824;
    else if (v < -64'sd1073741824) r = -32'sd1073741824;
    else r = q_t'(v);
    return r;
  endfunction

  // (a*b + 2^29) >>> 30 on clamped Q30 operands
  function automatic logic signed [33:0] mul_q30(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 34'(p >>> 30);
  endfunction
endpackage
`default_nettype wire

// ===== hdl/exr_cordic_cell.sv =====
// One rotation-mode CORDIC stage for one angle; registered output.
// Depends on exr_pkg.
`default_nettype none
module exr_cordic_cell
  import exr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire logic [4:0] stage_i,
  input  wire cstate_t    s_i,
  output cstate_t         s_o
);
  cstate_t s_d, s_q;
  cw_t dx, dy;
  // stage_i is tied to a constant per cell, so the shifts reduce to wiring
  always_comb begin
    dx = s_i.y >>> stage_i;
    dy = s_i.x >>> stage_i;
    s_d = s_i;
    if (!s_i.z[AW-1]) begin
      s_d.x = s_i.x - dx; s_d.y = s_i.y + dy; s_d.z = s_i.z - atan_tab(int'(stage_i));
    end else begin
      s_d.x = s_i.x + dx; s_d.y = s_i.y - dy; s_d.z = s_i.z + atan_tab(int'(stage_i));
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) s_q <= s_d;
  end
  assign s_o = s_q;
endmodule
`default_nettype wire

// ===== hdl/exr_matrix.sv =====
// Matrix build and row products, registered stages after each multiply level.
// Depends on exr_pkg.
`default_nettype none
module exr_matrix
  import exr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [2:0]        en_i,
  input  wire q_t                sx_i, cx_i, sy_i, cy_i, sz_i, cz_i,
  input  wire logic signed [31:0] cx_in_i, cy_in_i, cz_in_i,
  output logic signed [31:0]     rx_o, ry_o, rz_o,
  output logic                   ovf_o
);
  // level 1: sx*sy, cx*sy, keep sines/cosines
  q_t sxsy_q, cxsy_q, sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  logic signed [31:0] c1_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sxsy_q <= clamp_one(64'(mul_q30(sx_i, sy_i)));
      cxsy_q <= clamp_one(64'(mul_q30(cx_i, sy_i)));
      sx_q <= sx_i; cx_q <= cx_i; sy_q <= sy_i; cy_q <= cy_i;
      sz_q <= sz_i; cz_q <= cz_i;
      c1_q[0] <= cx_in_i; c1_q[1] <= cy_in_i; c1_q[2] <= cz_in_i;
    end
  end
  // level 2: matrix entries
  q_t m_q [9];
  logic signed [31:0] c2_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      m_q[0] <= clamp_one(64'(mul_q30(cz_q, cy_q)));
      m_q[1] <= clamp_one(-64'(mul_q30(cy_q, sz_q)));
      m_q[2] <= sy_q;
      m_q[3] <= clamp_one(64'(mul_q30(cx_q, sz_q)) + 64'(mul_q30(cz_q, sxsy_q)));
      m_q[4] <= clamp_one(64'(mul_q30(cz_q, cx_q)) - 64'(mul_q30(sz_q, sxsy_q)));
      m_q[5] <= clamp_one(-64'(mul_q30(cy_q, sx_q)));
      m_q[6] <= clamp_one(64'(mul_q30(sz_q, sx_q)) - 64'(mul_q30(cz_q, cxsy_q)));
      m_q[7] <= clamp_one(64'(mul_q30(cz_q, sx_q)) + 64'(mul_q30(sz_q, cxsy_q)));
      m_q[8] <= clamp_one(64'(mul_q30(cy_q, cx_q)));
      c2_q <= c1_q;
    end
  end
  // level 3: products, then sum/round/saturate combinationally into output reg
  logic signed [63:0] p_q [9];
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int k = 0; k < 9; k++) p_q[k] <= 64'(m_q[k]) * 64'(c2_q[k % 3]);
    end
  end
  logic signed [65:0] acc [3];
  logic signed [35:0] v [3];
  logic signed [31:0] r [3];
  logic [2:0] of;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = 66'(p_q[3*k]) + 66'(p_q[3*k+1]) + 66'(p_q[3*k+2]) + 66'sd536870912;
      v[k] = 36'(acc[k] >>> 30);
      of[k] = 1'b0;
      if (v[k] > 36'sd2147483647) begin
        r[k] = 32'sh7fffffff; of[k] = 1'b1;
      end else if (v[k] < -36'sd2147483648) begin
        r[k] = 32'sh80000000; of[k] = 1'b1;
      end else begin
        r[k] = 32'(v[k]);
      end
    end
  end
  assign rx_o = r[0];
  assign ry_o = r[1];
  assign rz_o = r[2];
  assign ovf_o = |of;
endmodule
`default_nettype wire

// ===== hdl/euler_xyz_vector_rotation.sv =====
// Euler XYZ rotation, pipelined: one transaction per cycle while the output is not stalled.
// Pipeline: 1 pre-rotate register, CORDIC stages (16), 3 matrix levels and 1 output
// register; the chain of CORDIC cells sets the depth.
// A stall freezes the whole pipeline; valid bits clear on async reset.
// Depends on exr_pkg, exr_cordic_cell, exr_matrix and the macros header.
`include "euler_xyz_vector_rotation_macros.svh"
`default_nettype none
module euler_xyz_vector_rotation
  import exr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] coord_x_i, coord_y_i, coord_z_i,
  input  wire logic [15:0] angle_x_i, angle_y_i, angle_z_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      rotated_x_o, rotated_y_o, rotated_z_o,
  output logic             overflow_o
);
  localparam int Depth = NStages + 4;  // pre, cordic, 3 matrix levels
  logic [Depth-1:0] vld_q;
  logic adv;
  logic signed [31:0] ox_q, oy_q, oz_q;
  logic oo_q, ov_q;
  assign adv = !ov_q || !stall_i;
  assign stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], valid_i};
  end

  cstate_t pre_d [3], pre_q [3];
  cstate_t chain [3][NStages+1];
  logic signed [31:0] cd_q [NStages+1][3];
  logic [15:0] ang [3];
  assign ang[0] = angle_x_i;
  assign ang[1] = angle_y_i;
  assign ang[2] = angle_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [31:0] p;
      cw_t z;
      p = 32'(ang[a][AngleBits-1:0]) << (32 - AngleBits);
      z = 34'(signed'(p));
      pre_d[a].flip = 1'b0;
      if (z > OneQ) begin
        z = z - 34'sd2147483648; pre_d[a].flip = 1'b1;
      end else if (z < -OneQ) begin
        z = z + 34'sd2147483648; pre_d[a].flip = 1'b1;
      end
      pre_d[a].x = Gain;
      pre_d[a].y = '0;
      pre_d[a].z = z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pre_q <= pre_d;
      cd_q[0][0] <= coord_x_i; cd_q[0][1] <= coord_y_i; cd_q[0][2] <= coord_z_i;
      for (int s = 1; s <= NStages; s++) cd_q[s] <= cd_q[s-1];
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_ang
    assign chain[a][0] = pre_q[a];
    for (genvar s = 0; s < NStages; s++) begin : g_st
      exr_cordic_cell u_cell (
        .clk_i(clk_i), .en_i(adv), .stage_i(5'(s)), .s_i(chain[a][s]),
        .s_o(chain[a][s+1])
      );
    end
  end

  q_t sn [3], cs [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cw_t x, y;
      x = chain[a][NStages].x;
      y = chain[a][NStages].y;
      if (chain[a][NStages].flip) begin
        x = -x; y = -y;
      end
      cs[a] = clamp_one(64'(x));
      sn[a] = clamp_one(64'(y));
    end
  end

  logic signed [31:0] rx, ry, rz;
  logic ovf;
  exr_matrix u_matrix (
    .clk_i(clk_i), .en_i({3{adv}}),
    .sx_i(sn[0]), .cx_i(cs[0]), .sy_i(sn[1]), .cy_i(cs[1]),
    .sz_i(sn[2]), .cz_i(cs[2]),
    .cx_in_i(cd_q[NStages][0]), .cy_in_i(cd_q[NStages][1]),
    .cz_in_i(cd_q[NStages][2]),
    .rx_o(rx), .ry_o(ry), .rz_o(rz), .ovf_o(ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= vld_q[Depth-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q <= rx; oy_q <= ry; oz_q <= rz; oo_q <= ovf;
    end
  end

  assign valid_o = ov_q;
  assign rotated_x_o = ox_q;
  assign rotated_y_o = oy_q;
  assign rotated_z_o = oz_q;
  assign overflow_o = oo_q;

  `EXR_ASSERT(a_stall_only_full, clk_i, rst_ni, stall_o |-> (valid_o && stall_i))
  `EXR_ASSERT(a_out_hold, clk_i, rst_ni, (valid_o && stall_i) |=> $stable(rotated_x_o))
  `EXR_ASSERT(a_pipe_fill, clk_i, rst_ni, (valid_i && !stall_o) |=> vld_q[0])
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for euler_xyz_vector_rotation: directed and random points and angles,
// checked against a behavioral CORDIC and rotation-matrix predictor.
// Depends on exr_pkg and the RTL of the block.
`timescale 1ns / 1ps
module testbench
  import exr_pkg::*;
();

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [15:0] angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] rotated_x_o, rotated_y_o, rotated_z_o;
  logic        overflow_o;

  euler_xyz_vector_rotation dut (.*);

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        ovf;
  } rot_t;

  rot_t rotated_q[$];
  int   mismatches = 0;
  int   points_sent = 0;
  int   points_checked = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  localparam logic signed [63:0] ONE = 64'sd1073741824;
  localparam logic signed [63:0] HALF = 64'sd536870912;

  function automatic logic signed [63:0] sat_one(logic signed [63:0] v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    return (a * b + HALF) >>> 30;
  endfunction

  // Phase in 32-bit turn units, folded into +-90 deg, then fixed-length CORDIC.
  task automatic cordic_sincos(input logic [15:0] ang,
                               output logic signed [63:0] s, output logic signed [63:0] c);
    logic signed [63:0] ph, x, y, dx, dy;
    logic [31:0] atans [24];
    logic        flip;
    int          nst;
    atans = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
              41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    ph = 64'(signed'(32'(ang) << (32 - AngleBits)));
    flip = 1'b0;
    if (ph > ONE) begin
      ph -= 64'sd2147483648;
      flip = 1'b1;
    end else if (ph < -ONE) begin
      ph += 64'sd2147483648;
      flip = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    nst = (CordicStages < 24) ? CordicStages : 24;
    for (int i = 0; i < nst; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ph >= 0) begin
        x -= dx; y += dy; ph -= 64'(atans[i]);
      end else begin
        x += dx; y -= dy; ph += 64'(atans[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = sat_one(x);
    s = sat_one(y);
  endtask

  task automatic predict_rotation(input logic [31:0] px, py, pz,
                                  input logic [15:0] ax, ay, az);
    logic signed [63:0] sx, cx, sy, cy, sz, cz, sxsy, cxsy, acc, v;
    logic signed [63:0] m [3][3];
    logic signed [63:0] p [3];
    logic [31:0] outv [3];
    rot_t r;
    p[0] = 64'(signed'(px)); p[1] = 64'(signed'(py)); p[2] = 64'(signed'(pz));
    cordic_sincos(ax, sx, cx);
    cordic_sincos(ay, sy, cy);
    cordic_sincos(az, sz, cz);
    sxsy = qmul(sx, sy);
    cxsy = qmul(cx, sy);
    m[0][0] = qmul(cz, cy);
    m[0][1] = -qmul(cy, sz);
    m[0][2] = sy;
    m[1][0] = qmul(cx, sz) + qmul(cz, sxsy);
    m[1][1] = qmul(cz, cx) - qmul(sz, sxsy);
    m[1][2] = -qmul(cy, sx);
    m[2][0] = qmul(sz, sx) - qmul(cz, cxsy);
    m[2][1] = qmul(cz, sx) + qmul(sz, cxsy);
    m[2][2] = qmul(cy, cx);
    r.ovf = 1'b0;
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += sat_one(m[k][j]) * p[j];
      v = (acc + HALF) >>> 30;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647; r.ovf = 1'b1;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648; r.ovf = 1'b1;
      end
      outv[k] = v[31:0];
    end
    r.x = outv[0]; r.y = outv[1]; r.z = outv[2];
    rotated_q.push_back(r);
  endtask

  // Hold the point until accepted; valid stays high across back-to-back sends.
  task automatic send_point(input logic [31:0] px, py, pz, input logic [15:0] ax, ay, az);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    coord_x_i <= px; coord_y_i <= py; coord_z_i <= pz;
    angle_x_i <= ax; angle_y_i <= ay; angle_z_i <= az;
    predict_rotation(px, py, pz, ax, ay, az);
    points_sent++;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic go_idle();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    go_idle();
    while (rotated_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    rot_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected transaction x=%h y=%h z=%h ovf=%b", $time,
                 rotated_x_o, rotated_y_o, rotated_z_o, overflow_o);
        mismatches++;
      end else begin
        want = rotated_q.pop_front();
        points_checked++;
        if (rotated_x_o !== want.x) begin
          $display("%0t: rotated_x expected %h actual %h", $time, want.x, rotated_x_o);
          mismatches++;
        end
        if (rotated_y_o !== want.y) begin
          $display("%0t: rotated_y expected %h actual %h", $time, want.y, rotated_y_o);
          mismatches++;
        end
        if (rotated_z_o !== want.z) begin
          $display("%0t: rotated_z expected %h actual %h", $time, want.z, rotated_z_o);
          mismatches++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, want.ovf, overflow_o);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
      3: return $urandom_range(32'h4000_0000) - 32'h2000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'(($urandom_range(7)) << 13);
      1: return 16'(($urandom_range(7)) << 13) + 16'($urandom_range(4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] pts [6];
    logic [15:0] angs [8];
    pts = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
            32'h5555_AAAA};
    angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h4001, 16'h3FFF,
             16'h2000};
    // quadrant edges, fold boundary, full-scale coordinates that saturate
    for (int i = 0; i < 8; i++)
      send_point(pts[i % 6], pts[(i + 1) % 6], pts[(i + 2) % 6], angs[i], angs[(i + 3) % 8],
                 angs[(i + 5) % 8]);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, 16'h2000, 16'h2000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h2000, 16'hE000, 16'h6000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'hAAAA, 16'h5555, 16'h1234);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++)
      send_point(pick_coord(), pick_coord(), pick_coord(), pick_angle(), pick_angle(),
                 pick_angle());
    wait_drained();
    recv_stall_pct = 0;
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    for (int i = 0; i < 10; i++)
      send_point(pick_coord(), pick_coord(), pick_coord(), pick_angle(), pick_angle(),
                 pick_angle());
    // sender holds off until the pipeline has emptied
    wait_drained();
    for (int i = 0; i < 10; i++)
      send_point(pick_coord(), pick_coord(), pick_coord(), pick_angle(), pick_angle(),
                 pick_angle());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(400, 0, 0);
    test_random(400, 53, 0);
    test_random(400, 0, 53);
    test_random(400, 24, 24);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d points, checked %0d rotations, with directed angle/saturation cases",
             points_sent, points_checked);
    $display("and random traffic under sender gaps and receiver stalls.");
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
